### src/bmh_pkg.sv
// Package of widths, codes and the entry type for the binary min-heap engine.
package bmh_pkg;

    localparam int KEY_W     = 32;
    localparam int TAG_W     = 16;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_DEF = 256;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

endpackage

### src/binary_min_heap_engine_top.sv
// Binary min-heap priority queue engine with a single-port sequenced sift unit.
//
// A request is taken on the rising edge where start is high and busy is low; op, key
// and payload are sampled at that edge. Insert appends the entry and sifts it up,
// remove returns the root and sifts the last entry down from the root, and peek
// returns the root unchanged. Each request gives exactly one result, shown for one
// cycle with done high on out_key, out_payload, status and count. The receiver
// cannot stall, so results are never held back.
// The entries live in one memory with one write and one registered read port,
// and one key comparator serves every step. Insert climbs one level per pass
// through S_UP_RD and S_UP_CMP, which read the parent, compare and move it down.
// Remove reads the root in S_RM_ROOT and the last entry in S_RM_LAST, then for
// each level descended reads the children in S_DN_L and S_DN_R, picks the smaller
// in S_DN_RC and compares it with the held entry in S_DN_CMP. Peek reads the root,
// and an empty, full or unused request finishes straight from idle. busy stays high
// until the cycle with done; such requests never raise it.
// Reset clears the entry count and the sequencer; the memory is not cleared,
// since only entries below the count are ever read.
module binary_min_heap_engine_top #(
    parameter int DEPTH = bmh_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bmh_pkg::OP_W-1:0]      op,
    input  logic [bmh_pkg::KEY_W-1:0]     key,
    input  logic [bmh_pkg::TAG_W-1:0]     payload,
    output logic                          done,
    output logic [bmh_pkg::KEY_W-1:0]     out_key,
    output logic [bmh_pkg::TAG_W-1:0]     out_payload,
    output logic [bmh_pkg::STATUS_W-1:0]  status,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = ADDR_W + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_PEEK,
        S_RM_ROOT,
        S_RM_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_RC,
        S_DN_CMP
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]            pos_reg, pos_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    bmh_pkg::entry_t              hold_reg, hold_next;
    bmh_pkg::entry_t              child_reg, child_next;
    logic [ADDR_W-1:0]            child_idx_reg, child_idx_next;
    logic [bmh_pkg::KEY_W-1:0]    out_key_reg, out_key_next;
    logic [bmh_pkg::TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic [bmh_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         done_reg, done_next;

    bmh_pkg::entry_t              heap_mem [DEPTH];
    bmh_pkg::entry_t              rd_data_reg;
    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_wa;
    logic [ADDR_W-1:0]            mem_ra;
    bmh_pkg::entry_t              mem_wd;

    logic [bmh_pkg::KEY_W-1:0]    cmp_a;
    logic [bmh_pkg::KEY_W-1:0]    cmp_b;
    logic                         cmp_lt;

    logic [CNT_W-1:0]             cnt_m1;
    logic [ADDR_W-1:0]            pos_m1;
    logic [ADDR_W-1:0]            parent_idx;
    logic [IDX_W-1:0]             left_x;
    logic [IDX_W-1:0]             right_x;
    logic [IDX_W-1:0]             count_x;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= heap_mem[mem_ra];
    end

    assign cnt_m1     = count_reg - 1'b1;
    assign pos_m1     = pos_reg - 1'b1;
    assign parent_idx = pos_m1 >> 1;
    assign left_x     = {1'b0, pos_reg, 1'b1};
    assign right_x    = left_x + 1'b1;
    assign count_x    = IDX_W'(count_reg);

    always_comb
    begin
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = hold_reg.key;
                cmp_b = rd_data_reg.key;
            end
            S_DN_RC:
            begin
                cmp_a = rd_data_reg.key;
                cmp_b = child_reg.key;
            end
            default:
            begin
                cmp_a = child_reg.key;
                cmp_b = hold_reg.key;
            end
        endcase
    end

    assign cmp_lt = cmp_a < cmp_b;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        hold_next      = hold_reg;
        child_next     = child_reg;
        child_idx_next = child_idx_reg;
        out_key_next   = out_key_reg;
        out_tag_next   = out_tag_reg;
        status_next    = status_reg;
        done_next      = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = pos_reg;
        mem_wd         = hold_reg;
        mem_ra         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    out_key_next = '0;
                    out_tag_next = '0;
                    status_next  = bmh_pkg::ST_OK;
                    case (op)
                        bmh_pkg::OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = bmh_pkg::ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                hold_next  = '{key: key, tag: payload};
                                pos_next   = count_reg[ADDR_W-1:0];
                                count_next = count_reg + 1'b1;
                                state_next = S_UP_RD;
                            end
                        end
                        bmh_pkg::OP_REMOVE, bmh_pkg::OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = bmh_pkg::ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = (op == bmh_pkg::OP_PEEK) ? S_PEEK : S_RM_ROOT;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_ra     = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_lt)
                begin
                    mem_wd     = rd_data_reg;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PEEK:
            begin
                out_key_next = rd_data_reg.key;
                out_tag_next = rd_data_reg.tag;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            S_RM_ROOT:
            begin
                out_key_next = rd_data_reg.key;
                out_tag_next = rd_data_reg.tag;
                mem_ra       = cnt_m1[ADDR_W-1:0];
                count_next   = cnt_m1;
                state_next   = S_RM_LAST;
            end
            S_RM_LAST:
            begin
                hold_next = rd_data_reg;
                pos_next  = '0;
                if (count_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DN_L;
                end
            end
            S_DN_L:
            begin
                if (left_x >= count_x)
                begin
                    mem_we     = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_ra     = left_x[ADDR_W-1:0];
                    state_next = S_DN_R;
                end
            end
            S_DN_R:
            begin
                child_next     = rd_data_reg;
                child_idx_next = left_x[ADDR_W-1:0];
                if (right_x < count_x)
                begin
                    mem_ra     = right_x[ADDR_W-1:0];
                    state_next = S_DN_RC;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_RC:
            begin
                if (cmp_lt)
                begin
                    child_next     = rd_data_reg;
                    child_idx_next = right_x[ADDR_W-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_lt)
                begin
                    mem_wd     = child_reg;
                    pos_next   = child_idx_reg;
                    state_next = S_DN_L;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            status_reg  <= bmh_pkg::ST_OK;
            out_key_reg <= '0;
            out_tag_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            out_key_reg <= out_key_next;
            out_tag_reg <= out_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        hold_reg      <= hold_next;
        child_reg     <= child_next;
        child_idx_reg <= child_idx_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_tag_reg;
    assign status      = status_reg;
    assign count       = count_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result strobed while the sequencer is still working.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the heap depth.");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bmh_pkg::ST_FULL) |-> (count == CNT_W'(DEPTH)))
        else $error("Full status given while the heap has room.");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bmh_pkg::ST_EMPTY) |-> (count == '0))
        else $error("Empty status given while the heap holds entries.");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("Accepted request neither started work nor finished.");

endmodule
